### hdl/crc8pf_pkg.sv
// Constants, codes and CRC-8 fold function for the CRC-8 packet framer.
package crc8pf_pkg;

	localparam logic [7:0] SYNC0    = 8'hAA;
	localparam logic [7:0] SYNC1    = 8'h55;
	localparam logic [7:0] CRC_POLY = 8'h8C; // reflected 0x31
	localparam int BURST_MAX = 5;
	localparam int CNT_W     = $clog2(BURST_MAX + 1);

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_DATA  = 1'b1
	} cmd_t;

	typedef logic [7:0] byte_t;

	// Dallas/Maxim CRC-8, one byte folded in, LSB first
	function automatic byte_t crc8_fold(input byte_t crc, input byte_t data);
		byte_t c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### hdl/crc8_packet_framer_top.sv
// CRC-8 packet framer: command items in, framed byte stream out.
//
//  port group | dir | tdata / tuser / tlast
//  s_*        | in  | tdata: func_code[7:0], payload_length[15:8], data_byte[23:16]
//             |     | tuser: command (0 start, 1 data)
//  m_*        | out | tdata: out_byte[7:0]; tlast: frame_end
//
// The next item is taken in the cycle the last buffered byte moves to the output
// register. A start item gives 4 or 5 bytes, a data item in an open frame 1 or 2,
// a data item with no open frame none; s_tready is low while two or more are buffered.
// One output byte leaves per cycle through m_tdata unless m_tready low stalls it.
// Frame state and CRC update when an item is accepted, so the next item
// sees them at once. Reset clears frame state and empties the byte buffer.
// m_tready low stalls the output register, then the buffer, then s_tready.
module crc8_packet_framer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // func_code, payload_length, data_byte
	input  logic [0:0]  s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte
	output logic        m_tlast    // frame_end
);
	import crc8pf_pkg::*;

	// frame state
	logic        frame_open_q;
	logic [7:0]  bytes_left_q;
	byte_t       crc_q;

	// pending result bytes, entry 0 goes out next
	byte_t              byte_s1 [BURST_MAX];
	logic [BURST_MAX-1:0] last_s1;
	logic [CNT_W-1:0]   cnt_s1;

	logic   out_load, pop, accept;
	cmd_t   cmd;
	byte_t  func_code, payload_length, data_byte;
	byte_t  crc_hdr, crc_dat;

	byte_t              new_byte [BURST_MAX];
	logic [BURST_MAX-1:0] new_last;
	logic [CNT_W-1:0]   new_cnt;
	logic               nxt_open;
	logic [7:0]         nxt_left;
	byte_t              nxt_crc;
	logic [7:0]         left_dec;

	assign cmd            = cmd_t'(s_tuser[0]);
	assign func_code      = s_tdata[7:0];
	assign payload_length = s_tdata[15:8];
	assign data_byte      = s_tdata[23:16];

	assign out_load = !m_tvalid || m_tready;
	assign pop      = (cnt_s1 != '0) && out_load;
	assign s_tready = (cnt_s1 == '0) || ((cnt_s1 == CNT_W'(1)) && out_load);
	assign accept   = s_tvalid && s_tready;

	assign crc_hdr  = crc8_fold(crc8_fold(8'h00, func_code), payload_length);
	assign crc_dat  = crc8_fold(crc_q, data_byte);
	assign left_dec = bytes_left_q - 8'd1;

	always_comb begin
		for (int i = 0; i < BURST_MAX; i++) begin
			new_byte[i] = '0;
		end
		new_last = '0;
		new_cnt  = '0;
		nxt_open = frame_open_q;
		nxt_left = bytes_left_q;
		nxt_crc  = crc_q;
		case (cmd)
			CMD_START: begin
				new_byte[0] = SYNC0;
				new_byte[1] = SYNC1;
				new_byte[2] = func_code;
				new_byte[3] = payload_length;
				if (payload_length == 8'd0) begin
					new_byte[4] = crc_hdr;
					new_last[4] = 1'b1;
					new_cnt     = CNT_W'(5);
					nxt_open    = 1'b0;
					nxt_left    = 8'd0;
					nxt_crc     = 8'h00;
				end else begin
					new_cnt  = CNT_W'(4);
					nxt_open = 1'b1;
					nxt_left = payload_length;
					nxt_crc  = crc_hdr;
				end
			end
			CMD_DATA: begin
				if (frame_open_q) begin
					new_byte[0] = data_byte;
					nxt_left    = left_dec;
					if (left_dec == 8'd0) begin
						new_byte[1] = crc_dat;
						new_last[1] = 1'b1;
						new_cnt     = CNT_W'(2);
						nxt_open    = 1'b0;
						nxt_crc     = 8'h00;
					end else begin
						new_cnt = CNT_W'(1);
						nxt_crc = crc_dat;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			bytes_left_q <= '0;
			crc_q        <= '0;
			cnt_s1       <= '0;
		end else if (accept) begin
			frame_open_q <= nxt_open;
			bytes_left_q <= nxt_left;
			crc_q        <= nxt_crc;
			cnt_s1       <= new_cnt;
		end else if (pop) begin
			cnt_s1 <= cnt_s1 - CNT_W'(1);
		end
	end

	// buffer payload: load on accept, shift down on pop
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= new_byte;
			last_s1 <= new_last;
		end else if (pop) begin
			for (int i = 0; i < BURST_MAX - 1; i++) begin
				byte_s1[i] <= byte_s1[i+1];
			end
			byte_s1[BURST_MAX-1] <= '0;
			last_s1 <= last_s1 >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= (cnt_s1 != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			m_tdata <= byte_s1[0];
			m_tlast <= last_s1[0];
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_s1 <= CNT_W'(BURST_MAX))
		else $error("buffer count out of range");

	a_open_left: assert property (@(posedge clk) disable iff (!arst_n)
		frame_open_q |-> bytes_left_q != 8'd0)
		else $error("open frame with no bytes left");

	a_closed_crc: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_open_q |-> crc_q == 8'h00)
		else $error("crc not cleared with frame closed");

	a_ready_drain: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> cnt_s1 <= CNT_W'(1))
		else $error("ready while buffer holds several bytes");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd == CMD_DATA) && !frame_open_q |=> cnt_s1 == '0)
		else $error("data item with no frame produced output");

endmodule
